### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### hdl/eos_pkg.sv
// Constants and types for the orbit step pipeline.
`default_nettype none
package eos_pkg;
	localparam int STEP_W   = 17;
	localparam int METHOD_W = 2;
	localparam int DEN_W    = 19;

	localparam logic [STEP_W-1:0]   STEP_RESET   = 17'd655;
	localparam logic [METHOD_W-1:0] METHOD_RESET = 2'd0;
	localparam logic [DEN_W-1:0]    DEN_RESET    = 19'(65536 + (655 * 655) / 65536);

	// register indexes
	localparam logic REG_STEP   = 1'b0;
	localparam logic REG_METHOD = 1'b1;

	// method codes; the unused code runs as forward Euler
	localparam logic [METHOD_W-1:0] METHOD_FWD = 2'd0;
	localparam logic [METHOD_W-1:0] METHOD_BWD = 2'd1;
	localparam logic [METHOD_W-1:0] METHOD_SYM = 2'd2;

	localparam logic [44:0] ACC_CAP = {45{1'b1}};

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] res_x;
		logic signed [31:0] res_y;
		logic [31:0]        mag_x;
		logic [31:0]        mag_y;
		logic               neg_x;
		logic               neg_y;
		logic               sing;
		logic               clip;
		logic [63:0]        r2;
	} side_t;
endpackage
`default_nettype wire

### hdl/eos_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module eos_div #(
	parameter int D_W    = 32,
	parameter int Q_W    = 32,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [D_W-1:0]    rem_in,
	input  wire logic [D_W-1:0]    den_in,
	input  wire logic [Q_W-1:0]    low_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [Q_W-1:0]         quo,
	output logic [SIDE_W-1:0]      side_out
);
	logic              v_s    [Q_W];
	logic [D_W-1:0]    rem_s  [Q_W];
	logic [D_W-1:0]    den_s  [Q_W];
	logic [Q_W-1:0]    ql_s   [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];

	genvar k;
	generate
		for (k = 0; k < Q_W; k++) begin : g_step
			logic              vp;
			logic [D_W-1:0]    remp;
			logic [D_W-1:0]    denp;
			logic [Q_W-1:0]    qlp;
			logic [SIDE_W-1:0] sidep;
			logic [D_W:0]      trial;
			logic              ge;

			if (k == 0) begin : g_first
				assign vp    = in_valid;
				assign remp  = rem_in;
				assign denp  = den_in;
				assign qlp   = low_in;
				assign sidep = side_in;
			end else begin : g_next
				assign vp    = v_s[k-1];
				assign remp  = rem_s[k-1];
				assign denp  = den_s[k-1];
				assign qlp   = ql_s[k-1];
				assign sidep = side_s[k-1];
			end

			// ql holds dividend bits still to shift in, quotient bits enter at the bottom
			assign trial = {remp, qlp[Q_W-1]};
			assign ge    = trial >= {1'b0, denp};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= vp;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= ge ? D_W'(trial - {1'b0, denp}) : trial[D_W-1:0];
					den_s[k]  <= denp;
					ql_s[k]   <= {qlp[Q_W-2:0], ge};
					side_s[k] <= sidep;
				end
			end
		end
	endgenerate

	assign out_valid = v_s[Q_W-1];
	assign quo       = ql_s[Q_W-1];
	assign side_out  = side_s[Q_W-1];
endmodule
`default_nettype wire

### hdl/euler_orbit_step_2d.sv
// Top level: one Euler step of a 2D body under a unit central pull.
//
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | s_tdata: pos_x, pos_y, vel_x, vel_y
// m_*     | out | m_tvalid/m_tready  | m_tdata: new_pos_x..new_vel_y, m_tuser: flags
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while the skid register is empty; the bit-serial stages are the
// backward divider (32), square root (32), radius dividers (17) and acceleration dividers (45).
// Reset clears valid bits and config registers; no clearing pass.
// A full skid register stalls the whole pipeline; it empties when m_tready is high.
`default_nettype none
`include "assert_macros.svh"
module euler_orbit_step_2d (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,   // pos_x, pos_y, vel_x, vel_y
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // new_pos_x, new_pos_y, new_vel_x, new_vel_y
	output logic [1:0]        m_tuser,   // singular, saturated
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [16:0]  cfg_data
);
	localparam int SIDE_W = $bits(eos_pkg::side_t);

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	// {clip, value} saturated to the signed 32-bit range
	function automatic logic [32:0] sat48(input logic signed [47:0] v);
		if (v > 48'sd2147483647) begin
			return {1'b1, 32'h7FFF_FFFF};
		end else if (v < -48'sd2147483648) begin
			return {1'b1, 32'h8000_0000};
		end else begin
			return {1'b0, v[31:0]};
		end
	endfunction

	// ---------------- configuration ----------------
	logic [16:0] step_q;
	logic [1:0]  method_q;
	logic [18:0] den_q;
	logic [33:0] hsq;
	logic        is_bwd;
	logic        is_sym;

	assign cfg_ready = 1'b1;
	assign hsq       = {17'b0, step_q} * {17'b0, step_q};
	assign is_bwd    = (method_q == eos_pkg::METHOD_BWD);
	assign is_sym    = (method_q == eos_pkg::METHOD_SYM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= eos_pkg::STEP_RESET;
			method_q <= eos_pkg::METHOD_RESET;
			den_q    <= eos_pkg::DEN_RESET;
		end else begin
			den_q <= 19'h10000 + {1'b0, hsq[33:16]};
			if (cfg_valid) begin
				unique case (cfg_index)
					eos_pkg::REG_STEP:   step_q   <= cfg_data;
					eos_pkg::REG_METHOD: method_q <= cfg_data[1:0];
					default:             step_q   <= step_q;
				endcase
			end
		end
	end

	// ---------------- pipeline control ----------------
	logic skid_v_q;
	logic en;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// ---------------- s1..s3: h*v and p + h*v ----------------
	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0] x_s1, y_s1, vx_s1, vy_s1;
	logic signed [31:0] x_s2, y_s2, vx_s2, vy_s2;
	logic signed [31:0] x_s3, y_s3, vx_s3, vy_s3;
	logic [48:0]        pvx_s2, pvy_s2;
	logic signed [35:0] sx_s3, sy_s3;
	logic signed [35:0] hvx, hvy;

	assign hvx = $signed({3'b000, pvx_s2[48:16]});
	assign hvy = $signed({3'b000, pvy_s2[48:16]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= s_tdata[31:0];
			y_s1   <= s_tdata[63:32];
			vx_s1  <= s_tdata[95:64];
			vy_s1  <= s_tdata[127:96];
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			pvx_s2 <= {17'b0, mag32(vx_s1)} * {32'b0, step_q};
			pvy_s2 <= {17'b0, mag32(vy_s1)} * {32'b0, step_q};
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;
			sx_s3  <= {{4{x_s2[31]}}, x_s2} + (vx_s2[31] ? -hvx : hvx);
			sy_s3  <= {{4{y_s2[31]}}, y_s2} + (vy_s2[31] ? -hvy : hvy);
		end
	end

	// ---------------- s4: forward result, backward divide setup ----------------
	logic [35:0]         msx, msy;
	logic [32:0]         fwd_x, fwd_y;
	eos_pkg::side_t      side_s4;
	logic [18:0]         remx_s4, remy_s4;
	logic [31:0]         lowx_s4, lowy_s4;
	logic                bigx_s4, bigy_s4, negx_s4, negy_s4;

	assign msx   = sx_s3[35] ? 36'(-sx_s3) : 36'(sx_s3);
	assign msy   = sy_s3[35] ? 36'(-sy_s3) : 36'(sy_s3);
	assign fwd_x = sat48({{12{sx_s3[35]}}, sx_s3});
	assign fwd_y = sat48({{12{sy_s3[35]}}, sy_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4       <= '0;
			side_s4.pos_x <= x_s3;
			side_s4.pos_y <= y_s3;
			side_s4.vel_x <= vx_s3;
			side_s4.vel_y <= vy_s3;
			side_s4.res_x <= fwd_x[31:0];
			side_s4.res_y <= fwd_y[31:0];
			// symplectic clips are collected at the end
			side_s4.clip  <= !is_sym && (fwd_x[32] || fwd_y[32]);
			remx_s4       <= msx[34:16];
			remy_s4       <= msy[34:16];
			lowx_s4       <= {msx[15:0], 16'b0};
			lowy_s4       <= {msy[15:0], 16'b0};
			bigx_s4       <= msx[35:16] >= {1'b0, den_q};
			bigy_s4       <= msy[35:16] >= {1'b0, den_q};
			negx_s4       <= sx_s3[35];
			negy_s4       <= sy_s3[35];
		end
	end

	logic              bdx_v, bdy_v;
	logic [31:0]       bdx_q, bdy_q;
	logic [SIDE_W+1:0] bdx_side;
	logic [1:0]        bdy_side;

	eos_div #(.D_W(19), .Q_W(32), .SIDE_W(SIDE_W + 2)) u_bdiv_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.rem_in(remx_s4), .den_in(den_q), .low_in(lowx_s4),
		.side_in({bigx_s4, negx_s4, side_s4}),
		.out_valid(bdx_v), .quo(bdx_q), .side_out(bdx_side)
	);

	eos_div #(.D_W(19), .Q_W(32), .SIDE_W(2)) u_bdiv_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.rem_in(remy_s4), .den_in(den_q), .low_in(lowy_s4),
		.side_in({bigy_s4, negy_s4}),
		.out_valid(bdy_v), .quo(bdy_q), .side_out(bdy_side)
	);

	// ---------------- s5: backward position, pick the point for the pull ----------------
	eos_pkg::side_t bd_side;
	logic           bxclip, byclip;
	logic [31:0]    bx_val, by_val;
	logic           v_s5, v_s6, v_s7, v_s8;
	eos_pkg::side_t side_s5, side_s6, side_s7, side_s8;
	logic [31:0]    px_s5, py_s5;
	logic [63:0]    sqx_s7, sqy_s7, ssum_s8;

	assign bd_side = bdx_side[SIDE_W-1:0];
	assign bxclip  = bdx_side[SIDE_W+1] ||
		(bdx_side[SIDE_W] ? (bdx_q > 32'h8000_0000) : bdx_q[31]);
	assign byclip  = bdy_side[1] || (bdy_side[0] ? (bdy_q > 32'h8000_0000) : bdy_q[31]);
	assign bx_val  = bdx_side[SIDE_W] ? (bxclip ? 32'h8000_0000 : (~bdx_q + 32'd1))
		: (bxclip ? 32'h7FFF_FFFF : bdx_q);
	assign by_val  = bdy_side[0] ? (byclip ? 32'h8000_0000 : (~bdy_q + 32'd1))
		: (byclip ? 32'h7FFF_FFFF : bdy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s5 <= bdx_v && bdy_v;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= bd_side;
			if (is_bwd) begin
				side_s5.res_x <= bx_val;
				side_s5.res_y <= by_val;
				side_s5.clip  <= bxclip || byclip;
				px_s5         <= bx_val;
				py_s5         <= by_val;
			end else begin
				px_s5 <= bd_side.pos_x;
				py_s5 <= bd_side.pos_y;
			end
			side_s6       <= side_s5;
			side_s6.mag_x <= mag32(px_s5);
			side_s6.mag_y <= mag32(py_s5);
			side_s6.neg_x <= !px_s5[31] && (px_s5 != '0);
			side_s6.neg_y <= !py_s5[31] && (py_s5 != '0);
			side_s6.sing  <= (px_s5 == '0) && (py_s5 == '0);
			side_s7       <= side_s6;
			sqx_s7        <= {32'b0, side_s6.mag_x} * {32'b0, side_s6.mag_x};
			sqy_s7        <= {32'b0, side_s6.mag_y} * {32'b0, side_s6.mag_y};
			side_s8       <= side_s7;
			ssum_s8       <= sqx_s7 + sqy_s7;
		end
	end

	// ---------------- square root, one root bit per stage ----------------
	logic           sq_v_s    [32];
	logic [34:0]    sq_rem_s  [32];
	logic [31:0]    sq_root_s [32];
	logic [63:0]    sq_rad_s  [32];
	eos_pkg::side_t sq_side_s [32];

	genvar k;
	generate
		for (k = 0; k < 32; k++) begin : g_sqrt
			logic           vp;
			logic [34:0]    remp;
			logic [31:0]    rootp;
			logic [63:0]    radp;
			eos_pkg::side_t sidep;
			logic [34:0]    trial;
			logic [34:0]    test;
			logic           ge;

			if (k == 0) begin : g_first
				assign vp    = v_s8;
				assign remp  = '0;
				assign rootp = '0;
				assign radp  = ssum_s8;
				assign sidep = side_s8;
			end else begin : g_next
				assign vp    = sq_v_s[k-1];
				assign remp  = sq_rem_s[k-1];
				assign rootp = sq_root_s[k-1];
				assign radp  = sq_rad_s[k-1];
				assign sidep = sq_side_s[k-1];
			end

			// remainder stays below 2*root+1, so its top two bits are zero
			assign trial = {remp[32:0], radp[63:62]};
			assign test  = {1'b0, rootp, 2'b01};
			assign ge    = trial >= test;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_v_s[k] <= 1'b0;
				end else if (en) begin
					sq_v_s[k] <= vp;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					sq_rem_s[k]  <= ge ? (trial - test) : trial;
					sq_root_s[k] <= {rootp[30:0], ge};
					sq_rad_s[k]  <= {radp[61:0], 2'b00};
					sq_side_s[k] <= sidep;
				end
			end
		end
	endgenerate

	// ---------------- s9: r^2, then |p|/r dividers ----------------
	logic           v_s9;
	eos_pkg::side_t side_s9;
	logic [31:0]    r_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= sq_v_s[31];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s9    <= sq_side_s[31];
			side_s9.r2 <= {32'b0, sq_root_s[31]} * {32'b0, sq_root_s[31]};
			r_s9       <= sq_root_s[31];
		end
	end

	// |p| <= r, so the quotient |p|*2^16/r fits 17 bits
	logic              udx_v, udy_v;
	logic [16:0]       udx_q, udy_q;
	logic [SIDE_W-1:0] udx_side;
	logic              udy_side;

	eos_div #(.D_W(32), .Q_W(17), .SIDE_W(SIDE_W)) u_udiv_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s9),
		.rem_in({1'b0, side_s9.mag_x[31:1]}), .den_in(r_s9),
		.low_in({side_s9.mag_x[0], 16'b0}), .side_in(side_s9),
		.out_valid(udx_v), .quo(udx_q), .side_out(udx_side)
	);

	eos_div #(.D_W(32), .Q_W(17), .SIDE_W(1)) u_udiv_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s9),
		.rem_in({1'b0, side_s9.mag_y[31:1]}), .den_in(r_s9),
		.low_in({side_s9.mag_y[0], 16'b0}), .side_in(side_s9.neg_y),
		.out_valid(udy_v), .quo(udy_q), .side_out(udy_side)
	);

	// ---------------- s10: cap test and setup for u*2^32/r^2 ----------------
	eos_pkg::side_t ud_side;
	logic           v_s10;
	eos_pkg::side_t side_s10;
	logic [63:0]    remx_s10, remy_s10;
	logic [44:0]    lowx_s10, lowy_s10;
	logic           ovfx_s10, ovfy_s10, negy_s10;

	assign ud_side = udx_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= udx_v && udy_v;
		end
	end

	// quotient reaches 2^45 exactly when u >= r^2 * 2^13
	always_ff @(posedge clk) begin
		if (en) begin
			side_s10 <= ud_side;
			remx_s10 <= {60'b0, udx_q[16:13]};
			remy_s10 <= {60'b0, udy_q[16:13]};
			lowx_s10 <= {udx_q[12:0], 32'b0};
			lowy_s10 <= {udy_q[12:0], 32'b0};
			ovfx_s10 <= (ud_side.r2[63:4] == '0) && (udx_q >= {ud_side.r2[3:0], 13'b0});
			ovfy_s10 <= (ud_side.r2[63:4] == '0) && (udy_q >= {ud_side.r2[3:0], 13'b0});
			negy_s10 <= udy_side;
		end
	end

	logic              adx_v, ady_v;
	logic [44:0]       adx_q, ady_q;
	logic [SIDE_W:0]   adx_side;
	logic [1:0]        ady_side;

	eos_div #(.D_W(64), .Q_W(45), .SIDE_W(SIDE_W + 1)) u_adiv_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s10),
		.rem_in(remx_s10), .den_in(side_s10.r2), .low_in(lowx_s10),
		.side_in({ovfx_s10, side_s10}),
		.out_valid(adx_v), .quo(adx_q), .side_out(adx_side)
	);

	eos_div #(.D_W(64), .Q_W(45), .SIDE_W(2)) u_adiv_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s10),
		.rem_in(remy_s10), .den_in(side_s10.r2), .low_in(lowy_s10),
		.side_in({ovfy_s10, negy_s10}),
		.out_valid(ady_v), .quo(ady_q), .side_out(ady_side)
	);

	// ---------------- s11..s13: velocity update, symplectic position product ----------------
	eos_pkg::side_t ad_side;
	logic [44:0]    amx, amy;
	logic           v_s11, v_s12, v_s13;
	eos_pkg::side_t side_s11, side_s12, side_s13;
	logic           negy_s11;
	logic [61:0]    pax_s11, pay_s11;
	logic signed [47:0] hax, hay, sumvx, sumvy;
	logic [32:0]    svx, svy;
	logic [31:0]    nvx_s12, nvy_s12, nvx_s13, nvy_s13;
	logic [48:0]    pnx_s13, pny_s13;

	assign ad_side = adx_side[SIDE_W-1:0];
	assign amx     = ad_side.sing ? '0 : (adx_side[SIDE_W] ? eos_pkg::ACC_CAP : adx_q);
	assign amy     = ad_side.sing ? '0 : (ady_side[1] ? eos_pkg::ACC_CAP : ady_q);

	assign hax   = $signed({2'b00, pax_s11[61:16]});
	assign hay   = $signed({2'b00, pay_s11[61:16]});
	assign sumvx = {{16{side_s11.vel_x[31]}}, side_s11.vel_x} + (side_s11.neg_x ? -hax : hax);
	assign sumvy = {{16{side_s11.vel_y[31]}}, side_s11.vel_y} + (negy_s11 ? -hay : hay);
	assign svx   = sat48(sumvx);
	assign svy   = sat48(sumvy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s11 <= adx_v && ady_v;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s11      <= ad_side;
			side_s11.clip <= ad_side.clip ||
				(!ad_side.sing && (adx_side[SIDE_W] || ady_side[1]));
			negy_s11      <= ady_side[0];
			pax_s11       <= {17'b0, amx} * {45'b0, step_q};
			pay_s11       <= {17'b0, amy} * {45'b0, step_q};
			side_s12      <= side_s11;
			side_s12.clip <= side_s11.clip || svx[32] || svy[32];
			nvx_s12       <= svx[31:0];
			nvy_s12       <= svy[31:0];
			side_s13      <= side_s12;
			nvx_s13       <= nvx_s12;
			nvy_s13       <= nvy_s12;
			pnx_s13       <= {17'b0, mag32(nvx_s12)} * {32'b0, step_q};
			pny_s13       <= {17'b0, mag32(nvy_s12)} * {32'b0, step_q};
		end
	end

	// ---------------- last stage: symplectic position, result select ----------------
	logic signed [47:0] hnx, hny, sumpx, sumpy;
	logic [32:0]        spx, spy;
	logic [129:0]       res;

	assign hnx   = $signed({15'b0, pnx_s13[48:16]});
	assign hny   = $signed({15'b0, pny_s13[48:16]});
	assign sumpx = {{16{side_s13.pos_x[31]}}, side_s13.pos_x} + (nvx_s13[31] ? -hnx : hnx);
	assign sumpy = {{16{side_s13.pos_y[31]}}, side_s13.pos_y} + (nvy_s13[31] ? -hny : hny);
	assign spx   = sat48(sumpx);
	assign spy   = sat48(sumpy);

	// {saturated, singular, vel_y, vel_x, pos_y, pos_x}
	assign res = {
		side_s13.clip || (is_sym && (spx[32] || spy[32])),
		side_s13.sing,
		nvy_s13,
		nvx_s13,
		is_sym ? spy[31:0] : side_s13.res_y,
		is_sym ? spx[31:0] : side_s13.res_x
	};

	// ---------------- output register and skid ----------------
	logic         out_v_q;
	logic [129:0] out_q;
	logic [129:0] skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s13) begin
			if (out_v_q && !m_tready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (v_s13) begin
			if (out_v_q && !m_tready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q[127:0];
	assign m_tuser  = out_q[129:128];

	// ---------------- checks ----------------
	`ASSERT_IMPLY(a_skid_needs_out, clk, arst_n, skid_v_q, out_v_q, "skid full with output empty")
	`ASSERT_NEVER(a_bdiv_lanes, clk, arst_n, bdx_v != bdy_v, "backward divider lanes out of step")
	`ASSERT_NEVER(a_udiv_lanes, clk, arst_n, udx_v != udy_v, "radius divider lanes out of step")
	`ASSERT_NEVER(a_adiv_lanes, clk, arst_n, adx_v != ady_v, "accel divider lanes out of step")
endmodule
`default_nettype wire
